// File: hw/rtl/max_priority_queue_unique_keys_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max-first priority queue
// Shared concurrent assertion forms used by the queue modules.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_UNIQUE_KEYS_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_UNIQUE_KEYS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Constants, codes and types shared by the priority queue cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpq_pkg;

   // Sizing
   localparam int DEPTH       = 16;
   localparam int ITEM_BITS   = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);

   // Fixed port field widths
   localparam int FUNC_W      = 2;
   localparam int PRI_W       = 16;
   localparam int ITEM_W      = 32;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 5;

   // Request functions
   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_PRI  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

   // Chain operations broadcast to every cell
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_HOLD    = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH    = 3'd1;  // insert in order or overwrite key
   localparam logic [OP_W-1:0] OP_POP     = 3'd2;  // shift whole chain toward head
   localparam logic [OP_W-1:0] OP_KILL    = 3'd3;  // drop entries holding the tag
   localparam logic [OP_W-1:0] OP_COMPACT = 3'd4;  // close holes by one step

   // Contents of one cell
   typedef struct packed {
      logic                    valid;
      logic signed [PRI_W-1:0] pri;
      logic [ITEM_BITS-1:0]    tag;
   } cell_state_type;

   // Broadcast command
   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [PRI_W-1:0] pri;
      logic [ITEM_BITS-1:0]    tag;
   } cell_cmd_type;

   // Per-cell compare results
   typedef struct packed {
      logic gt;     // holds a higher priority than the command
      logic eq;     // holds exactly the command priority
      logic match;  // holds the command tag
   } cell_flags_type;

endpackage

// File: hw/rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds an entry and moves it to a neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_priority_queue_unique_keys_defines.svh"

module mpq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  mpq_pkg::cell_cmd_type   cmd,
   input  logic                    key_hit,
   input  mpq_pkg::cell_state_type left_state,
   input  logic                    left_gt,
   input  mpq_pkg::cell_state_type right_state,
   output mpq_pkg::cell_state_type state,
   output mpq_pkg::cell_flags_type flags
);
   import mpq_pkg::*;

   logic                    valid_ff;
   logic signed [PRI_W-1:0] pri_ff;
   logic [ITEM_BITS-1:0]    tag_ff;
   cell_state_type          cur;
   cell_state_type          state_in;

   assign cur = '{valid: valid_ff, pri: pri_ff, tag: tag_ff};
   assign state = cur;

   // Local compares against the broadcast command
   assign flags.gt    = valid_ff && (pri_ff > cmd.pri);
   assign flags.eq    = valid_ff && (pri_ff == cmd.pri);
   assign flags.match = valid_ff && (tag_ff == cmd.tag);

   // Next contents
   always_comb begin
      state_in = cur;
      unique case (cmd.op)
         OP_HOLD: begin
            state_in = cur;
         end
         OP_PUSH: begin
            if (key_hit) begin
               // existing key: only its tag changes
               if (flags.eq) begin
                  state_in.tag = cmd.tag;
               end
            end else if (!flags.gt) begin
               // insertion point takes the new entry, cells behind shift down
               if (left_gt) begin
                  state_in = '{valid: 1'b1, pri: cmd.pri, tag: cmd.tag};
               end else begin
                  state_in = left_state;
               end
            end
         end
         OP_POP: begin
            state_in = right_state;
         end
         OP_KILL: begin
            if (flags.match) begin
               state_in.valid = 1'b0;
            end
         end
         OP_COMPACT: begin
            // a hole pulls from the right; an entry behind a hole leaves
            if (!valid_ff) begin
               state_in = right_state;
            end else if (!left_state.valid) begin
               state_in.valid = 1'b0;
            end
         end
         default: begin
            state_in = cur;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= state_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      pri_ff <= state_in.pri;
      tag_ff <= state_in.tag;
   end

   // Valid entries stay in strictly descending priority order
   `MPQ_ASSERT_IMPLY(a_cell_sorted, clock, reset,
      valid_ff && right_state.valid, pri_ff > right_state.pri,
      "cell order broken")

endmodule

// File: hw/rtl/max_priority_queue_unique_keys.sv
// ----------------------------------------------------------------------------
// max_priority_queue_unique_keys
// Max-first priority queue with unique keys, built as a sorted cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (valid/ready): push, pop highest, or change the
//   priority of a tag. Each request returns exactly one response on rsp_*
//   carrying status, popped tag and the entry count after the operation.
//   The chain is kept sorted with the highest priority at cell 0, so pop reads
//   cell 0 and key lookup is a single broadcast compare over all cells.
//   Responses: push, pop and any rejected request are answered from the
//   response register loaded at the accepting edge. A successful change
//   kills the tagged entries, closes the holes in k compaction steps
//   (0 to DEPTH - 1), each moving entries one cell, then pushes and responds.
//   Throughput: one transaction per cycle for push and pop while the
//   receiver keeps rsp_ready high; a change holds req_ready low until done.
//   A new request is taken while a response waits only in the cycle that
//   response is taken.
//   Reset clears all valid bits and the count; the queue starts empty.
//   A stalled receiver holds the response in its register and blocks
//   further requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_priority_queue_unique_keys_defines.svh"

module max_priority_queue_unique_keys (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic        [mpq_pkg::FUNC_W-1:0]     req_func,
   input  logic signed [mpq_pkg::PRI_W-1:0]      req_priority_req,
   input  logic        [mpq_pkg::ITEM_W-1:0]     req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [mpq_pkg::STATUS_W-1:0]   rsp_status,
   output logic        [mpq_pkg::ITEM_W-1:0]     rsp_item_out,
   output logic        [mpq_pkg::COUNT_OUT_W-1:0] rsp_entry_count
);
   import mpq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   logic                    state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [PRI_W-1:0] pend_pri_ff;
   logic [ITEM_BITS-1:0]    pend_tag_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [ITEM_W-1:0]       rsp_item_ff;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff;

   cell_cmd_type            cmd;
   cell_state_type          cell_st [DEPTH];
   cell_flags_type          cell_fl [DEPTH];
   cell_state_type          left_st [DEPTH];
   cell_state_type          right_st[DEPTH];
   logic [DEPTH-1:0]        left_gt;

   logic [DEPTH-1:0]        valid_vec, eq_vec, match_vec, last_vec;
   logic [DEPTH-2:0]        hole_vec;
   logic                    key_hit, tag_hit, full, compact_ok;
   logic [CNT_W-1:0]        cnt_calc;
   logic [ITEM_BITS-1:0]    req_tag;
   logic                    pri_ok, accept;

   logic                    res_fire;
   logic [STATUS_W-1:0]     res_status;
   logic [ITEM_W-1:0]       res_item;
   logic [CNT_W-1:0]        res_cnt;

   assign req_tag = ITEM_BITS'(req_item);
   assign pri_ok  = (req_priority_req > 0);
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept  = req_valid && req_ready;

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         // head boundary: always "higher" and never a hole
         assign left_st[i] = '{valid: 1'b1, pri: '0, tag: '0};
         assign left_gt[i] = 1'b1;
      end else begin : g_body
         assign left_st[i] = cell_st[i-1];
         assign left_gt[i] = cell_fl[i-1].gt;
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_st[i] = '{valid: 1'b0, pri: '0, tag: '0};
      end else begin : g_mid
         assign right_st[i] = cell_st[i+1];
      end

      mpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key_hit     (key_hit),
         .left_state  (left_st[i]),
         .left_gt     (left_gt[i]),
         .right_state (right_st[i]),
         .state       (cell_st[i]),
         .flags       (cell_fl[i])
      );

      assign valid_vec[i] = cell_st[i].valid;
      assign eq_vec[i]    = cell_fl[i].eq;
      assign match_vec[i] = cell_fl[i].match;
   end

   // Chain-wide summaries
   assign key_hit = |eq_vec;
   assign tag_hit = |match_vec;
   assign full    = valid_vec[DEPTH-1];
   assign hole_vec   = ~valid_vec[DEPTH-2:0] & valid_vec[DEPTH-1:1];
   assign compact_ok = ~|hole_vec;
   assign last_vec   = valid_vec & ~{1'b0, valid_vec[DEPTH-1:1]};

   // Entry count of a compact chain: position of the last valid cell
   always_comb begin
      cnt_calc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (last_vec[i]) begin
            cnt_calc = cnt_calc | CNT_W'(i + 1);
         end
      end
   end

   // Sequencer: broadcast command and response
   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_HOLD;
      cmd.pri    = (state_ff == S_IDLE) ? req_priority_req : pend_pri_ff;
      cmd.tag    = (state_ff == S_IDLE) ? req_tag : pend_tag_ff;
      res_fire   = 1'b0;
      res_status = STAT_OK;
      res_item   = '0;
      res_cnt    = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_PUSH: begin
                     res_fire = 1'b1;
                     priority if (!pri_ok) begin
                        res_status = STAT_BAD_PRI;
                     end else if (key_hit) begin
                        cmd.op = OP_PUSH;
                     end else if (full) begin
                        res_status = STAT_FULL;
                     end else begin
                        cmd.op  = OP_PUSH;
                        res_cnt = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_POP: begin
                     res_fire = 1'b1;
                     if (!valid_vec[0]) begin
                        res_status = STAT_EMPTY;
                     end else begin
                        cmd.op   = OP_POP;
                        res_item = ITEM_W'(cell_st[0].tag);
                        res_cnt  = count_ff - CNT_W'(1);
                     end
                  end
                  FUNC_CHANGE: begin
                     priority if (!pri_ok) begin
                        res_fire   = 1'b1;
                        res_status = STAT_BAD_PRI;
                     end else if (!tag_hit) begin
                        res_fire   = 1'b1;
                        res_status = STAT_NOTFOUND;
                     end else begin
                        cmd.op   = OP_KILL;
                        state_in = S_BUSY;
                     end
                  end
                  default: begin
                     res_fire = 1'b1;
                  end
               endcase
            end
         end
         S_BUSY: begin
            if (compact_ok) begin
               // room is guaranteed: at least one entry was removed
               cmd.op   = OP_PUSH;
               res_fire = 1'b1;
               res_cnt  = key_hit ? cnt_calc : cnt_calc + CNT_W'(1);
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_COMPACT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign count_in     = res_fire ? res_cnt : count_ff;
   assign rsp_valid_in = res_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_pri_ff <= req_priority_req;
         pend_tag_ff <= req_tag;
      end
      if (res_fire) begin
         rsp_status_ff <= res_status;
         rsp_item_ff   <= res_item;
         rsp_count_ff  <= COUNT_OUT_W'(res_cnt);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_item_out    = rsp_item_ff;
   assign rsp_entry_count = rsp_count_ff;

   // A new response never lands on one still waiting
   `MPQ_ASSERT_IMPLY(a_rsp_no_overwrite, clock, reset,
      res_fire, !rsp_valid_ff || rsp_ready, "response overwritten")

   // Between operations the chain has no holes
   `MPQ_ASSERT_IMPLY(a_idle_compact, clock, reset,
      state_ff == S_IDLE, compact_ok, "holes left in chain")

   // Tracked count agrees with the chain contents
   `MPQ_ASSERT_IMPLY(a_count_track, clock, reset,
      state_ff == S_IDLE, count_ff == cnt_calc, "entry count mismatch")

   // A successful change enters the compaction phase
   `MPQ_ASSERT_NEXT(a_change_busy, clock, reset,
      accept && (req_func == FUNC_CHANGE) && pri_ok && tag_hit,
      state_ff == S_BUSY, "change did not start")

endmodule
